@@ hw/rtl/double_ended_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue core.
// Each macro checks at the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold whenever the antecedent holds in the same cycle.
`define DQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Property whose consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT_SAME(label, ante, cons, msg)
`define DQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hw/rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Types, sizes and helper functions shared by the double-ended queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Storage sizes.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed widths of the item fields.
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes carried by an input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } act_t;

  // Status codes reported with each result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  shift_r;  // push front: every element moves one cell back
    logic                  shift_l;  // pop front: every element moves one cell forward
    logic                  wr_tail;  // push back: the cell at the fill level is written
    logic [DATA_WIDTH-1:0] data;     // element being pushed
    logic [CNT_W-1:0]      count;    // fill level before the operation
  } dq_cell_ctl_t;

  // Sign-extend a stored element to the width of the result field.
  function automatic logic [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(v);
    return VALUE_W'(s);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dq_cell.sv @@
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue chain. Cell zero holds the front element and
// cell count-1 the back element; elements slide between neighbors on pushes
// and pops at the front.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      cell_idx,
  input  wire dq_cell_ctl_t          ctl,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic      [DATA_WIDTH-1:0] tail_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  is_first;
  logic                  is_fill;
  logic                  is_last;

  // Position of this cell relative to the current fill level.
  assign is_first = (cell_idx == '0);
  assign is_fill  = (CNT_W'(cell_idx) == ctl.count);
  assign is_last  = ((CNT_W'(cell_idx) + CNT_W'(1)) == ctl.count);

  // Select the new content of the cell.
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_r) begin
      data_nxt = is_first ? ctl.data : left_data;
    end else if (ctl.shift_l) begin
      data_nxt = right_data;
    end else if (ctl.wr_tail && is_fill) begin
      data_nxt = ctl.data;
    end
  end

  // Element storage; content is meaningless until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Only the back cell drives its element onto the shared back read.
  assign tail_o = is_last ? data_r : '0;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed values built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_action, in_value_in) is accepted at a rising edge where start
//   is high and busy is low. busy stays low, so an item may be offered in
//   every cycle. Actions: push front/back, pop front/back, peek front/back.
//   Each accepted item yields exactly one result item on the out_ ports in
//   the following cycle, marked by a one-cycle out_valid strobe.
//   Throughput is one item per cycle: the cell row shifts or writes in the
//   same edge that registers the result, and the back element is read
//   through a one-hot select across the cells.
//   Results report the value, a status (ok, empty, full), the count after
//   the operation and empty/full flags. Errors leave the queue unchanged.
//   The receiver cannot stall; a result is present for one cycle only.
//   Reset (rst_n low, synchronous) empties the queue and clears out_valid.
//   Cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core
  import dq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic        [ACTION_W-1:0] in_action,
  input  wire logic signed [VALUE_W-1:0]  in_value_in,
  output logic                            out_valid,
  output logic signed      [VALUE_W-1:0]  out_value_out,
  output logic             [STATUS_W-1:0] out_status,
  output logic             [COUNT_W-1:0]  out_count,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  logic                  accept;
  logic                  q_empty;
  logic                  q_full;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  dq_cell_ctl_t          cell_ctl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
  logic [DATA_WIDTH-1:0] back_data;
  logic [VALUE_W-1:0]    result;
  status_t               status;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  status_t               out_status_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_empty_r;
  logic                  out_full_r;

  // The core never holds off an item, so busy is tied low.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));

  // Decode the item into a cell command, the new count and the result.
  always_comb begin
    cell_ctl       = '0;
    cell_ctl.data  = DATA_WIDTH'(in_value_in);
    cell_ctl.count = count_r;
    count_nxt      = count_r;
    result         = '0;
    status         = ST_OK;
    if (accept) begin
      case (act_t'(in_action))
        ACT_PUSH_FRONT: begin
          if (q_full) begin
            status = ST_FULL;
          end else begin
            cell_ctl.shift_r = 1'b1;
            count_nxt        = count_r + CNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (q_full) begin
            status = ST_FULL;
          end else begin
            cell_ctl.wr_tail = 1'b1;
            count_nxt        = count_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (q_empty) begin
            status = ST_EMPTY;
          end else begin
            result           = widen(cell_data[0]);
            cell_ctl.shift_l = 1'b1;
            count_nxt        = count_r - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (q_empty) begin
            status = ST_EMPTY;
          end else begin
            result    = widen(back_data);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ACT_PEEK_FRONT: begin
          if (q_empty) begin
            status = ST_EMPTY;
          end else begin
            result = widen(cell_data[0]);
          end
        end
        ACT_PEEK_BACK: begin
          if (q_empty) begin
            status = ST_EMPTY;
          end else begin
            result = widen(back_data);
          end
        end
        default: begin
          // Unused codes leave the queue alone and report ok.
          result = '0;
        end
      endcase
    end
  end

  // Row of cells; each takes its neighbors' elements when the row shifts.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctl        (cell_ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i]),
      .tail_o     (cell_tail[i])
    );
  end

  // Only the back cell drives a nonzero tail, so an OR collects it.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  // Fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= result;
      out_status_r <= status;
      out_count_r  <= COUNT_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CNT_W'(DEPTH));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;

  // Checks on the queue control.
  `DQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count beyond depth")
  `DQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted item gave no result")
  `DQ_ASSERT_NEXT(a_no_spurious, !accept, !out_valid, "result without an item")
  `DQ_ASSERT_SAME(a_full_status, out_valid && out_status_r == ST_FULL,
                  out_full_r && count_r == CNT_W'(DEPTH), "full status on non-full queue")
  `DQ_ASSERT_SAME(a_empty_status, out_valid && out_status_r == ST_EMPTY,
                  out_empty_r && out_value_r == '0, "empty status with data")
  `DQ_ASSERT_NEXT(a_count_step, accept,
                  (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1))
                  || (count_r == $past(count_r) - CNT_W'(1)), "count moved by more than one")

endmodule

`default_nettype wire
